@@ design/art_pkg.sv @@
// Package: shared constants, status codes and control types of the allocation record table.
`timescale 1ns / 1ps
package art_pkg;

   localparam int CAPACITY   = 64;
   localparam int ADDR_WIDTH = 32;

   localparam int POS_W   = 32;
   localparam int SIZE_W  = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;

   // key bits actually compared
   localparam int KEY_W = (ADDR_WIDTH < POS_W) ? ADDR_WIDTH : POS_W;
   // internal record counter, holds 0..CAPACITY
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;  // latch request beat
      logic commit;   // apply operation, load result register
   } art_cmd_type;

endpackage

@@ design/art_if.sv @@
// Interfaces: request and response channels of the allocation record table.
`timescale 1ns / 1ps
interface art_req_if import art_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [POS_W-1:0]  chunk_pos;
   logic [SIZE_W-1:0] chunk_size;

   modport source (output valid, output cmd, output chunk_pos, output chunk_size, input ready);
   modport sink   (input valid, input cmd, input chunk_pos, input chunk_size, output ready);
endinterface

interface art_rsp_if import art_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SIZE_W-1:0]  result_size;
   logic [STAT_W-1:0]  status;
   logic [COUNT_W-1:0] chunk_count;

   modport source (output valid, output result_size, output status, output chunk_count,
                   input ready);
   modport sink   (input valid, input result_size, input status, input chunk_count,
                   output ready);
endinterface

@@ design/allocation_record_table.sv @@
// Top level: allocation record table, controller plus cell datapath.
//
//   channel   dir   beat payload                              handshake
//   req_bus   in    cmd, chunk_pos, chunk_size                valid/ready
//   rsp_bus   out   result_size, status, chunk_count          valid/ready
//
// Each beat runs a match state, which compares the key against all cells in parallel
// (registered match vector), then a commit state, which picks the newest match,
// updates the cells and loads the result register. A new request is taken in the
// commit cycle, so the next beat's capture overlaps the current beat's commit.
// Reset (synchronous) empties the table; cell contents are not cleared, only the count.
// A stalled response holds the block in commit until the result register frees up.
`timescale 1ns / 1ps
module allocation_record_table import art_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   art_req_if.sink   req_bus,
   art_rsp_if.source rsp_bus
);

   art_cmd_type ctl;

   art_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl)
   );

   art_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_cmd         (req_bus.cmd),
      .req_chunk_pos   (req_bus.chunk_pos),
      .req_chunk_size  (req_bus.chunk_size),
      .rsp_result_size (rsp_bus.result_size),
      .rsp_status      (rsp_bus.status),
      .rsp_chunk_count (rsp_bus.chunk_count)
   );

endmodule

@@ design/art_datapath.sv @@
// Datapath: record cells, parallel match, newest-match select, gap close and result register.
`timescale 1ns / 1ps
module art_datapath import art_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  art_cmd_type        ctl,
   input  logic               req_cmd,
   input  logic [POS_W-1:0]   req_chunk_pos,
   input  logic [SIZE_W-1:0]  req_chunk_size,
   output logic [SIZE_W-1:0]  rsp_result_size,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0] rsp_chunk_count
);

   // latched request
   logic              cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [SIZE_W-1:0] size_ff;

   // record cells, oldest at index 0
   logic [KEY_W-1:0]  pos_ff  [CAPACITY];
   logic [SIZE_W-1:0] sz_ff   [CAPACITY];
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [CAPACITY-1:0] match_ff, match_in;
   logic [CAPACITY-1:0] above;     // some match sits above this cell
   logic [CAPACITY-1:0] hit_oh;    // newest match, one-hot
   logic [CAPACITY-1:0] shift_en;  // cell takes its upper neighbor
   logic                found;
   logic [SIZE_W-1:0]   found_size;
   logic                full;

   logic [SIZE_W-1:0]  res_size_ff, res_size_in;
   logic [STAT_W-1:0]  res_stat_ff, res_stat_in;
   logic [CNT_W-1:0]   res_cnt_ff;
   logic [CNT_W+COUNT_W-1:0] cnt_ext;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_cmd;
         key_ff  <= req_chunk_pos[KEY_W-1:0];
         size_ff <= req_chunk_size;
      end
   end

   // compare stage: every live cell against the key
   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         match_in[j] = (pos_ff[j] == key_ff) && (CNT_W'(j) < count_ff);
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
   end

   always_comb begin
      found_size = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         above[j]    = |(match_ff >> (j + 1));
         hit_oh[j]   = match_ff[j] & ~above[j];
         found_size  = found_size | (hit_oh[j] ? sz_ff[j] : '0);
      end
      found    = |match_ff;
      shift_en = found ? ~above : '0;
      full     = (count_ff >= CNT_W'(CAPACITY));
   end

   always_comb begin
      count_in    = count_ff;
      res_size_in = '0;
      res_stat_in = ST_OK;
      if (cmd_ff == CMD_ADD) begin
         if (full) begin
            res_stat_in = ST_FULL;
         end else begin
            count_in    = count_ff + CNT_W'(1);
            res_size_in = size_ff;
         end
      end else begin
         if (found) begin
            count_in    = count_ff - CNT_W'(1);
            res_size_in = found_size;
         end else begin
            res_stat_in = ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.commit) begin
         count_ff <= count_in;
      end
   end

   // cell updates: append at the top, or close the gap above the removed record
   always_ff @(posedge clock) begin
      for (int j = 0; j < CAPACITY; j++) begin
         if (ctl.commit) begin
            if (cmd_ff == CMD_ADD) begin
               if (!full && (CNT_W'(j) == count_ff)) begin
                  pos_ff[j] <= key_ff;
                  sz_ff[j]  <= size_ff;
               end
            end else if (shift_en[j] && (j + 1 < CAPACITY)) begin
               pos_ff[j] <= pos_ff[(j + 1 < CAPACITY) ? j + 1 : j];
               sz_ff[j]  <= sz_ff[(j + 1 < CAPACITY) ? j + 1 : j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         res_size_ff <= res_size_in;
         res_stat_ff <= res_stat_in;
         res_cnt_ff  <= count_in;
      end
   end

   assign cnt_ext         = {{COUNT_W{1'b0}}, res_cnt_ff};
   assign rsp_result_size = res_size_ff;
   assign rsp_status      = res_stat_ff;
   assign rsp_chunk_count = cnt_ext[COUNT_W-1:0];

endmodule

@@ design/art_ctrl.sv @@
// Controller: sequences capture, match and commit, and owns the response valid flag.
`timescale 1ns / 1ps
module art_ctrl import art_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output art_cmd_type ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_load;

   assign can_load    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE) || ((state_ff == S_EXEC) && can_load);
   assign ctl.capture = req_valid && req_ready;
   assign ctl.commit  = (state_ff == S_EXEC) && can_load;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (ctl.capture) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (ctl.capture) begin
               state_in = S_MATCH;
            end else if (ctl.commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/art_checker.sv @@
// Checker: port-level assertions for the allocation record table, with its bind.
`timescale 1ns / 1ps
module art_checker import art_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SIZE_W-1:0]  rsp_result_size,
   input logic [STAT_W-1:0]  rsp_status,
   input logic [COUNT_W-1:0] rsp_chunk_count
);

   // a taken request needs a match cycle before the next one
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken in match cycle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_size)
                                     && $stable(rsp_status) && $stable(rsp_chunk_count)))
      else $error("stalled response changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_result_size == '0))
      else $error("failed beat carries a size");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_chunk_count == COUNT_W'(CAPACITY)))
      else $error("full reported below capacity");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_OK) || (rsp_status == ST_NOT_FOUND)
                     || (rsp_status == ST_FULL)))
      else $error("undefined status code");

endmodule

bind allocation_record_table art_checker u_art_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_result_size (rsp_bus.result_size),
   .rsp_status      (rsp_bus.status),
   .rsp_chunk_count (rsp_bus.chunk_count)
);
